// ----- hdl/cipq_pkg.sv -----
// ----------------------------------------------------------------------------
// cipq_pkg
// Shared types and constants of the channel interrupt priority queue.
// ----------------------------------------------------------------------------
package cipq_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned LINE_W   = 8;
  localparam int unsigned WORD_W   = CODE_W + LINE_W;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // operation codes carried in kind
  localparam logic [KIND_W-1:0] KIND_RAISE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQUEUE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_PRIO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE   = 2'd2;

  localparam logic [CODE_W-1:0] CLEAR_CODE_RST = 8'd0;
  localparam logic [CODE_W-1:0] TOP_PRIO_RST   = 8'd7;
  localparam logic [CODE_W-1:0] EMPTY_CODE_RST = 8'd0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] int_code;
    logic [LINE_W-1:0] line_number;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_word;
    logic               read_valid;
    logic               irq_request;
    logic               overflow;
    logic [LEVEL_W-1:0] queue_level;
  } result_t;

  typedef struct packed {
    logic [CODE_W-1:0] clear_code;
    logic [CODE_W-1:0] top_priority_code;
    logic [CODE_W-1:0] empty_code;
  } cfg_t;

endpackage

// ----- hdl/cipq_in_if.sv -----
// ----------------------------------------------------------------------------
// cipq_in_if
// Command channel of the interrupt queue: valid/ready with one command.
// ----------------------------------------------------------------------------
interface cipq_in_if;
  logic                         valid;
  logic                         ready;
  logic [cipq_pkg::KIND_W-1:0]  kind;
  logic [cipq_pkg::CODE_W-1:0]  int_code;
  logic [cipq_pkg::LINE_W-1:0]  line_number;

  modport source (output valid, kind, int_code, line_number, input ready);
  modport sink   (input valid, kind, int_code, line_number, output ready);
endinterface

// ----- hdl/cipq_out_if.sv -----
// ----------------------------------------------------------------------------
// cipq_out_if
// Result channel of the interrupt queue: valid/ready with one result.
// ----------------------------------------------------------------------------
interface cipq_out_if;
  logic                          valid;
  logic                          ready;
  logic [cipq_pkg::WORD_W-1:0]   read_word;
  logic                          read_valid;
  logic                          irq_request;
  logic                          overflow;
  logic [cipq_pkg::LEVEL_W-1:0]  queue_level;

  modport source (output valid, read_word, read_valid, irq_request, overflow, queue_level,
                  input ready);
  modport sink   (input valid, read_word, read_valid, irq_request, overflow, queue_level,
                  output ready);
endinterface

// ----- hdl/cipq_core.sv -----
// ----------------------------------------------------------------------------
// cipq_core
// Circular entry store with head pointer, fill count and a registered copy
// of the head entry; computes one result per step.
// ----------------------------------------------------------------------------
module cipq_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cipq_pkg::item_t   item_i,
  input  cipq_pkg::cfg_t    cfg_i,
  output cipq_pkg::result_t result_o
);
  import cipq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);

  logic [WORD_W-1:0] mem [QUEUE_DEPTH];

  logic [IW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [WORD_W-1:0] rd_q;
  logic              byp_q;
  logic [WORD_W-1:0] byp_data_q;

  logic [WORD_W-1:0] head_word;
  logic [WORD_W-1:0] new_item;
  logic [IW-1:0]     head_inc, head_dec, tail_idx;
  logic [SW-1:0]     tail_sum;
  logic              full, empty;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  // head entry: either just written, or read from the store at the last step
  assign head_word = byp_q ? byp_data_q : rd_q;
  assign new_item  = {item_i.int_code, item_i.line_number};

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - IW'(1);
  assign tail_sum = SW'(head_q) + SW'(count_q);
  always_comb begin
    if (tail_sum >= DEPTH_S) begin
      tail_idx = IW'(tail_sum - DEPTH_S);
    end else begin
      tail_idx = IW'(tail_sum);
    end
  end

  assign full  = (count_q == FULL_CNT);
  assign empty = (count_q == '0);

  always_comb begin
    head_d               = head_q;
    count_d              = count_q;
    we                   = 1'b0;
    waddr                = tail_idx;
    wdata                = new_item;
    result_o.read_word   = '0;
    result_o.read_valid  = 1'b0;
    result_o.irq_request = 1'b0;
    result_o.overflow    = 1'b0;
    case (item_i.kind)
      KIND_RAISE: begin
        if (item_i.int_code == cfg_i.clear_code) begin
          head_d               = '0;
          count_d              = CW'(1);
          we                   = 1'b1;
          waddr                = '0;
          result_o.irq_request = 1'b1;
        end else if (full) begin
          result_o.overflow = 1'b1;
        end else if (item_i.int_code <= cfg_i.top_priority_code) begin
          head_d               = head_dec;
          count_d              = count_q + CW'(1);
          we                   = 1'b1;
          waddr                = head_dec;
          result_o.irq_request = 1'b1;
        end else begin
          count_d              = count_q + CW'(1);
          we                   = 1'b1;
          result_o.irq_request = empty;
        end
      end
      KIND_READ: begin
        result_o.read_valid = 1'b1;
        if (empty) begin
          result_o.read_word = {cfg_i.empty_code, LINE_W'(0)};
        end else begin
          result_o.read_word   = head_word;
          head_d               = head_inc;
          count_d              = count_q - CW'(1);
          result_o.irq_request = (count_q != CW'(1));
        end
      end
      KIND_REQUEUE: begin
        if (!empty) begin
          we                   = 1'b1;
          wdata                = head_word;
          head_d               = head_inc;
          result_o.irq_request = 1'b1;
        end
      end
      default: begin
      end
    endcase
    result_o.queue_level = LEVEL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else if (step_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      byp_q   <= we && (waddr == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rd_q       <= mem[head_d];
      byp_data_q <= wdata;
    end
  end

endmodule

// ----- hdl/channel_interrupt_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// channel_interrupt_priority_queue_unit
// Pending-interrupt queue of an I/O channel: raise, read-and-pop, requeue.
//
//   port     dir  payload                                         role
//   in_ch    in   kind, int_code, line_number                     commands
//   out_ch   out  read_word, read_valid, irq_request, overflow,   one result
//                 queue_level                                     per command
//   cfg_*    in   cfg_we_i, cfg_idx_i, cfg_data_i                 register writes
//
// One command per clock sustained while the output is not stalled; a command
// is held in the input register and its result is registered in the output
// register. The head entry is kept registered beside the store so every
// command needs only one store write and one store read per cycle.
// Reset clears pointer, count and valid flags; the store itself is not cleared.
// A stalled output holds the input register; new commands are taken while
// the input register is empty or the result register is free or being drained.
// ----------------------------------------------------------------------------
module channel_interrupt_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cipq_in_if.sink                          in_ch,
  cipq_out_if.source                       out_ch,
  input  logic                             cfg_we_i,
  input  logic [cipq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cipq_pkg::CFG_W-1:0]       cfg_data_i
);
  import cipq_pkg::*;

  cfg_t    cfg_q;
  item_t   in_q;
  logic    in_valid_q;
  result_t out_q, result;
  logic    out_valid_q;
  logic    step;

  // step moves the buffered command through the queue into the result register
  assign step         = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clear_code        <= CLEAR_CODE_RST;
      cfg_q.top_priority_code <= TOP_PRIO_RST;
      cfg_q.empty_code        <= EMPTY_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLEAR_CODE: cfg_q.clear_code        <= cfg_data_i;
        CFG_TOP_PRIO:   cfg_q.top_priority_code <= cfg_data_i;
        CFG_EMPTY_CODE: cfg_q.empty_code        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_q <= in_ch.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q.kind        <= in_ch.kind;
      in_q.int_code    <= in_ch.int_code;
      in_q.line_number <= in_ch.line_number;
    end
    if (step) begin
      out_q <= result;
    end
  end

  cipq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign out_ch.valid       = out_valid_q;
  assign out_ch.read_word   = out_q.read_word;
  assign out_ch.read_valid  = out_q.read_valid;
  assign out_ch.irq_request = out_q.irq_request;
  assign out_ch.overflow    = out_q.overflow;
  assign out_ch.queue_level = out_q.queue_level;

endmodule
